/* rtl/core/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit bump arena allocator: table
// geometry, field widths, status codes, controller states and the table
// access request.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Table geometry
  localparam int unsigned MaxBlocks = 16;
  localparam int unsigned IdxW      = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned CntW      = $clog2(MaxBlocks + 1);

  // Field widths
  localparam int unsigned SizeW     = 24;
  localparam int unsigned CapW      = 25;
  localparam int unsigned BlkIdxW   = 4;

  // Capacity used when the base register holds zero
  localparam logic [CapW-1:0] DefaultBase = CapW'(4096);

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GROW,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  // One cycle of accesses to the block table
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            cap_we;
    logic            used_we;
    logic [IdxW-1:0] wr_addr;
    logic [CapW-1:0] cap_wdata;
    logic [CapW-1:0] used_wdata;
  } tbl_req_t;

endpackage

/* rtl/core/ffba_table.sv */
// ----------------------------------------------------------------------------
// ffba_table
// Block table: capacity and bump offset of each arena block, held in two
// synchronous memories sharing one read address and one write address.
// Read data is registered and only updates on a read enable.
// ----------------------------------------------------------------------------
module ffba_table (
  input  logic                           clk_i,
  input  ffba_pkg::tbl_req_t             req_i,
  output logic [ffba_pkg::CapW-1:0]      cap_o,
  output logic [ffba_pkg::CapW-1:0]      used_o
);

  logic [ffba_pkg::CapW-1:0] cap_mem  [ffba_pkg::MaxBlocks];
  logic [ffba_pkg::CapW-1:0] used_mem [ffba_pkg::MaxBlocks];
  logic [ffba_pkg::CapW-1:0] cap_rdata_q;
  logic [ffba_pkg::CapW-1:0] used_rdata_q;

  // Write capacities
  always_ff @(posedge clk_i) begin
    if (req_i.cap_we) begin
      cap_mem[req_i.wr_addr] <= req_i.cap_wdata;
    end
  end

  // Write offsets
  always_ff @(posedge clk_i) begin
    if (req_i.used_we) begin
      used_mem[req_i.wr_addr] <= req_i.used_wdata;
    end
  end

  // Read both entries of one block
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      cap_rdata_q  <= cap_mem[req_i.rd_addr];
      used_rdata_q <= used_mem[req_i.rd_addr];
    end
  end

  assign cap_o  = cap_rdata_q;
  assign used_o = used_rdata_q;

endmodule

/* rtl/core/first_fit_bump_arena_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_bump_arena_allocator_core
// Bump arena allocator with a first-fit search over a table of blocks.
// ----------------------------------------------------------------------------
// Usage:
//   A request (kind, request_size) is taken on in_valid_i & in_ready_o and
//   gives exactly one result (status, block_index, byte_offset, new_block)
//   on out_valid_o & out_ready_i. One request is processed at a time; the
//   next is taken the cycle after its result is loaded.
//   Allocate: size rounded up to 8 bytes, blocks read one per cycle from
//   index 0; the first with room serves it. Failing that a new block is
//   appended, its capacity doubled from the base size one step per cycle;
//   a full table gives status FULL and a zero size status ZERO.
//   Reset request: offsets of all existing blocks cleared, one per cycle.
//   The single read port of the block table sets the scan rate.
// Reset: no blocks, base size 4096. The table memories are not cleared;
//   only entries below the block count are ever read.
// Stall: the result is held in an output register; the next request is
//   accepted while it waits, but no new result is loaded until it is taken.
// base_block_size is written with cfg_we_i; the user must write it only
//   while no request is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module first_fit_bump_arena_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [ffba_pkg::CapW-1:0]     cfg_wdata_i,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [ffba_pkg::SizeW-1:0]    request_size_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ffba_pkg::BlkIdxW-1:0]  block_index_o,
  output logic [ffba_pkg::CapW-1:0]     byte_offset_o,
  output logic                          new_block_o
);

  ffba_pkg::state_e                 state_q, state_d;
  logic [ffba_pkg::CapW-1:0]        base_q;
  logic [ffba_pkg::CntW-1:0]        count_q, count_d;
  logic [ffba_pkg::CntW-1:0]        idx_q, idx_d;
  logic                             chk_valid_q, chk_valid_d;
  logic [ffba_pkg::IdxW-1:0]        chk_idx_q, chk_idx_d;
  logic [ffba_pkg::CapW-1:0]        size_q, size_d;
  logic [ffba_pkg::CapW-1:0]        cap_q, cap_d;

  // Pending result
  ffba_pkg::status_e                res_status_q, res_status_d;
  logic [ffba_pkg::BlkIdxW-1:0]     res_idx_q, res_idx_d;
  logic [ffba_pkg::CapW-1:0]        res_off_q, res_off_d;
  logic                             res_nb_q, res_nb_d;

  // Output register
  logic                             out_valid_q, out_valid_d;
  logic                             out_load;
  logic [1:0]                       out_status_q;
  logic [ffba_pkg::BlkIdxW-1:0]     out_idx_q;
  logic [ffba_pkg::CapW-1:0]        out_off_q;
  logic                             out_nb_q;

  ffba_pkg::tbl_req_t               tbl_req;
  logic [ffba_pkg::CapW-1:0]        rd_cap;
  logic [ffba_pkg::CapW-1:0]        rd_used;
  logic [ffba_pkg::CapW-1:0]        room;
  logic [ffba_pkg::CapW-1:0]        eff_base;
  logic [ffba_pkg::CapW-1:0]        size_round;
  logic                             in_accept;
  logic                             fits;

  ffba_table u_table (
    .clk_i  (clk_i),
    .req_i  (tbl_req),
    .cap_o  (rd_cap),
    .used_o (rd_used)
  );

  // Round the request size up to a multiple of 8
  assign size_round = (ffba_pkg::CapW'(request_size_i) + ffba_pkg::CapW'(7))
                      & ~ffba_pkg::CapW'(7);
  assign eff_base   = (base_q == '0) ? ffba_pkg::DefaultBase : base_q;
  assign room       = rd_cap - rd_used;
  assign fits       = chk_valid_q && (room >= size_q);
  assign in_ready_o = (state_q == ffba_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Hold the base block size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ffba_pkg::DefaultBase;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::ST_IDLE;
      count_q     <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and pending result registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    chk_idx_q    <= chk_idx_d;
    size_q       <= size_d;
    cap_q        <= cap_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_off_q    <= res_off_d;
    res_nb_q     <= res_nb_d;
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_off_q    <= res_off_q;
      out_nb_q     <= res_nb_q;
    end
  end

  // Next state, table accesses and results
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    chk_valid_d  = chk_valid_q;
    chk_idx_d    = chk_idx_q;
    size_d       = size_q;
    cap_d        = cap_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_off_d    = res_off_q;
    res_nb_d     = res_nb_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    tbl_req      = '0;

    case (state_q)
      ffba_pkg::ST_IDLE: begin
        if (in_accept) begin
          size_d       = size_round;
          idx_d        = '0;
          chk_valid_d  = 1'b0;
          res_status_d = ffba_pkg::STATUS_OK;
          res_idx_d    = '0;
          res_off_d    = '0;
          res_nb_d     = 1'b0;
          if (kind_i) begin
            state_d = (count_q == '0) ? ffba_pkg::ST_FINISH : ffba_pkg::ST_CLEAR;
          end else if (request_size_i == '0) begin
            res_status_d = ffba_pkg::STATUS_ZERO;
            state_d      = ffba_pkg::ST_FINISH;
          end else begin
            state_d = ffba_pkg::ST_SCAN;
          end
        end
      end

      ffba_pkg::ST_SCAN: begin
        if (fits) begin
          // Bump the offset of the first block with room
          tbl_req.used_we    = 1'b1;
          tbl_req.wr_addr    = chk_idx_q;
          tbl_req.used_wdata = rd_used + size_q;
          res_idx_d          = ffba_pkg::BlkIdxW'(chk_idx_q);
          res_off_d          = rd_used;
          chk_valid_d        = 1'b0;
          state_d            = ffba_pkg::ST_FINISH;
        end else if (idx_q < count_q) begin
          // Advance the read to the next block
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = idx_q[ffba_pkg::IdxW-1:0];
          chk_idx_d       = idx_q[ffba_pkg::IdxW-1:0];
          chk_valid_d     = 1'b1;
          idx_d           = idx_q + ffba_pkg::CntW'(1);
        end else if (chk_valid_q) begin
          chk_valid_d = 1'b0;
        end else if (count_q == ffba_pkg::CntW'(ffba_pkg::MaxBlocks)) begin
          res_status_d = ffba_pkg::STATUS_FULL;
          state_d      = ffba_pkg::ST_FINISH;
        end else begin
          cap_d   = eff_base;
          state_d = ffba_pkg::ST_GROW;
        end
      end

      ffba_pkg::ST_GROW: begin
        if (cap_q < size_q) begin
          cap_d = cap_q << 1;
        end else begin
          // Append the new block, its first allocation at offset zero
          tbl_req.cap_we     = 1'b1;
          tbl_req.used_we    = 1'b1;
          tbl_req.wr_addr    = count_q[ffba_pkg::IdxW-1:0];
          tbl_req.cap_wdata  = cap_q;
          tbl_req.used_wdata = size_q;
          res_idx_d          = ffba_pkg::BlkIdxW'(count_q);
          res_nb_d           = 1'b1;
          count_d            = count_q + ffba_pkg::CntW'(1);
          state_d            = ffba_pkg::ST_FINISH;
        end
      end

      ffba_pkg::ST_CLEAR: begin
        // Drop the offset of one block per cycle
        tbl_req.used_we    = 1'b1;
        tbl_req.wr_addr    = idx_q[ffba_pkg::IdxW-1:0];
        tbl_req.used_wdata = '0;
        idx_d              = idx_q + ffba_pkg::CntW'(1);
        if (idx_q + ffba_pkg::CntW'(1) == count_q) begin
          state_d = ffba_pkg::ST_FINISH;
        end
      end

      ffba_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ffba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ffba_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign block_index_o = out_idx_q;
  assign byte_offset_o = out_off_q;
  assign new_block_o   = out_nb_q;

endmodule
